// ----- rtl/core/scc_pkg.sv -----
package scc_pkg;

	localparam int MASK_W           = 64;
	localparam int SLOT_IDX_W       = 6;
	localparam int CNT_W            = 8;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 8;
	localparam int SLOT_COUNT_DEF   = 64;
	localparam int HEADER_SLOTS_DEF = 8;

	localparam logic [CNT_W-1:0]  CNT_MAX           = 8'hFF;
	localparam logic [CNT_W-1:0]  ENROLL_FRAMES_RST = 8'd50;
	localparam logic [CNT_W-1:0]  MISSING_LIMIT_RST = 8'd5;
	localparam logic [MASK_W-1:0] INTRUDER_WINDOW   = 64'h0000_0000_FFFF_FF00;

	localparam logic [CFG_IDX_W-1:0] CFG_BUS_RUNNING   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENROLL_FRAMES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MISSING_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_SLOT_A   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_SLOT_B   = 3'd4;

	typedef enum logic [1:0] {
		OP_ENROLL  = 2'd0,
		OP_FRAME   = 2'd1,
		OP_CONSENT = 2'd2
	} op_t;

	typedef struct packed {
		logic                  bus_running;
		logic [CNT_W-1:0]      enroll_frames;
		logic [CNT_W-1:0]      missing_limit;
		logic [SLOT_IDX_W-1:0] stop_slot_a;
		logic [SLOT_IDX_W-1:0] stop_slot_b;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [MASK_W-1:0] frame_mask;
		logic [MASK_W-1:0] photo_required;
	} req_t;

	typedef struct packed {
		logic              motion_ok;
		logic              enrolled;
		logic              roll_fault;
		logic [MASK_W-1:0] intruder_slots;
		logic [MASK_W-1:0] enrolled_slots;
	} res_t;

	typedef struct packed {
		logic                  upd;
		logic                  clr;
		logic [CNT_W-1:0]      limit;
		logic [SLOT_IDX_W-1:0] stop_a;
		logic [SLOT_IDX_W-1:0] stop_b;
	} lane_ctrl_t;

endpackage

// ----- rtl/core/scc_if.sv -----
interface scc_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 op;
	logic [scc_pkg::MASK_W-1:0] frame_mask;
	logic [scc_pkg::MASK_W-1:0] photo_required;

	modport source (output valid, output op, output frame_mask, output photo_required,
		input ready);
	modport sink (input valid, input op, input frame_mask, input photo_required,
		output ready);
endinterface

interface scc_res_if;
	logic                       valid;
	logic                       ready;
	logic                       motion_ok;
	logic                       enrolled;
	logic                       roll_fault;
	logic [scc_pkg::MASK_W-1:0] intruder_slots;
	logic [scc_pkg::MASK_W-1:0] enrolled_slots;

	modport source (output valid, output motion_ok, output enrolled, output roll_fault,
		output intruder_slots, output enrolled_slots, input ready);
	modport sink (input valid, input motion_ok, input enrolled, input roll_fault,
		input intruder_slots, input enrolled_slots, output ready);
endinterface

// ----- rtl/core/scc_lane.sv -----
module scc_lane #(
	parameter int SLOT_IDX = scc_pkg::HEADER_SLOTS_DEF
) (
	input  logic                clk,
	input  scc_pkg::lane_ctrl_t ctrl,
	input  logic                present,
	input  logic                enrolled,
	output logic                hit
);

	localparam logic [scc_pkg::SLOT_IDX_W-1:0] IDX = scc_pkg::SLOT_IDX_W'(SLOT_IDX);

	logic [scc_pkg::CNT_W-1:0] cnt_q;
	logic [scc_pkg::CNT_W-1:0] cnt_nx;
	logic                      checked;

	assign checked = enrolled && (IDX != ctrl.stop_a) && (IDX != ctrl.stop_b);

	always_comb begin
		if (present) begin
			cnt_nx = '0;
		end else if (cnt_q == scc_pkg::CNT_MAX) begin
			cnt_nx = cnt_q;
		end else begin
			cnt_nx = cnt_q + scc_pkg::CNT_W'(1);
		end
	end

	assign hit = ctrl.upd && checked && (cnt_nx >= ctrl.limit);

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			cnt_q <= '0;
		end else if (ctrl.upd && checked) begin
			cnt_q <= cnt_nx;
		end
	end

endmodule

// ----- rtl/core/scc_core.sv -----
module scc_core #(
	parameter int SLOT_COUNT   = scc_pkg::SLOT_COUNT_DEF,
	parameter int HEADER_SLOTS = scc_pkg::HEADER_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  scc_pkg::req_t req,
	input  scc_pkg::cfg_t cfg,
	output scc_pkg::res_t res
);

	localparam int W = scc_pkg::MASK_W;
	localparam logic [W-1:0] VALID_SLOTS = {W{1'b1}} >> (W - SLOT_COUNT);
	localparam logic [W-1:0] HEADER_BITS = (W'(1) << HEADER_SLOTS) - W'(1);

	logic [W-1:0]              set_q, set_nx;
	logic                      valid_q, valid_nx;
	logic                      enrolling_q, enrolling_nx;
	logic [W-1:0]              acc_q, acc_nx;
	logic [scc_pkg::CNT_W-1:0] ecnt_q, ecnt_nx;
	logic                      fault_q, fault_nx;
	logic [W-1:0]              intr_q, intr_nx;
	logic [W-1:0]              last_q, last_nx;
	logic [W-1:0]              m;
	logic [W-1:0]              acc_and;
	logic [scc_pkg::CNT_W-1:0] ecnt_inc;
	logic [W-1:0]              hit;
	logic                      ok;
	logic                      stop_a_ok;
	logic                      stop_b_ok;
	scc_pkg::lane_ctrl_t       lane_ctrl;

	assign m        = req.frame_mask & VALID_SLOTS & ~HEADER_BITS;
	assign acc_and  = acc_q & m;
	assign ecnt_inc = (ecnt_q == scc_pkg::CNT_MAX) ? ecnt_q : ecnt_q + scc_pkg::CNT_W'(1);

	assign stop_a_ok = !set_q[cfg.stop_slot_a] || last_q[cfg.stop_slot_a];
	assign stop_b_ok = !set_q[cfg.stop_slot_b] || last_q[cfg.stop_slot_b];

	always_comb begin
		set_nx        = set_q;
		valid_nx      = valid_q;
		enrolling_nx  = enrolling_q;
		acc_nx        = acc_q;
		ecnt_nx       = ecnt_q;
		intr_nx       = intr_q;
		last_nx       = last_q;
		ok            = 1'b0;
		lane_ctrl.upd    = 1'b0;
		lane_ctrl.clr    = 1'b0;
		lane_ctrl.limit  = cfg.missing_limit;
		lane_ctrl.stop_a = cfg.stop_slot_a;
		lane_ctrl.stop_b = cfg.stop_slot_b;
		unique case (scc_pkg::op_t'(req.op))
			scc_pkg::OP_ENROLL: begin
				acc_nx       = '1;
				ecnt_nx      = '0;
				enrolling_nx = 1'b1;
				valid_nx     = 1'b0;
			end
			scc_pkg::OP_FRAME: begin
				last_nx = m;
				if (enrolling_q) begin
					acc_nx  = acc_and;
					ecnt_nx = ecnt_inc;
					if (ecnt_inc >= cfg.enroll_frames) begin
						set_nx        = acc_and & ~HEADER_BITS & VALID_SLOTS;
						valid_nx      = 1'b1;
						enrolling_nx  = 1'b0;
						lane_ctrl.clr = go;
					end
				end else if (valid_q) begin
					lane_ctrl.upd = go;
					intr_nx       = m & ~set_q & scc_pkg::INTRUDER_WINDOW;
				end
			end
			scc_pkg::OP_CONSENT: begin
				ok = cfg.bus_running && valid_q && !fault_q && (intr_q == '0) &&
					((last_q & req.photo_required) == req.photo_required) &&
					stop_a_ok && stop_b_ok;
			end
			default: begin
			end
		endcase
	end

	// Fault is refreshed only when the lanes actually checked this frame.
	assign fault_nx = lane_ctrl.upd ? (|hit) : fault_q;

	for (genvar s = 0; s < W; s++) begin : g_lane
		if (s >= HEADER_SLOTS && s < SLOT_COUNT) begin : g_live
			scc_lane #(.SLOT_IDX(s)) u_lane (
				.clk      (clk),
				.ctrl     (lane_ctrl),
				.present  (m[s]),
				.enrolled (set_q[s]),
				.hit      (hit[s])
			);
		end else begin : g_dead
			assign hit[s] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q       <= '0;
			valid_q     <= 1'b0;
			enrolling_q <= 1'b0;
			acc_q       <= '0;
			ecnt_q      <= '0;
			fault_q     <= 1'b0;
			intr_q      <= '0;
			last_q      <= '0;
		end else if (go) begin
			set_q       <= set_nx;
			valid_q     <= valid_nx;
			enrolling_q <= enrolling_nx;
			acc_q       <= acc_nx;
			ecnt_q      <= ecnt_nx;
			fault_q     <= fault_nx;
			intr_q      <= intr_nx;
			last_q      <= last_nx;
		end
	end

	assign res.motion_ok      = ok;
	assign res.enrolled       = valid_nx;
	assign res.roll_fault     = fault_nx;
	assign res.intruder_slots = intr_nx;
	assign res.enrolled_slots = set_nx;

endmodule

// ----- rtl/core/slot_census_and_consent_unit.sv -----
// Slot census and motion consent for a frame bus of up to 64 slots.
// The req channel carries one item per request: begin an enrollment, the slot
// mask of a completed frame, or a motion consent query with its photo mask.
// The res channel returns exactly one item per request, in order, showing the
// consent answer and the enrolled, fault, intruder and enrolled-slot state as
// left by that request.
// Configuration registers are to be written through cfg_we, cfg_idx and
// cfg_wdata only while the block is idle; the block itself does not enforce
// this. Unknown indexes are ignored. An accepted item waits in the input
// register while all slot lanes work out their absence counters together;
// when the output register is free or being taken, the counters update and
// the result loads into the output register at the same edge. Sustained
// throughput is one item per cycle while the receiver does not stall.
// Reset clears the enrolment, fault and intruder state and loads the
// configuration defaults; absence counters hold no meaning until an
// enrollment completes and clears them.
// When the receiver stalls, the output register holds its item, the input
// register holds one more, and ready then drops until res is taken.
module slot_census_and_consent_unit #(
	parameter int SLOT_COUNT   = scc_pkg::SLOT_COUNT_DEF,
	parameter int HEADER_SLOTS = scc_pkg::HEADER_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [scc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [scc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	scc_req_if.sink                        req,
	scc_res_if.source                      res
);

	scc_pkg::cfg_t cfg_q;
	scc_pkg::req_t req_s1;
	logic          req_v_s1;
	scc_pkg::res_t out_q;
	logic          out_v_q;
	scc_pkg::res_t core_res;
	logic          adv;
	logic          go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bus_running   <= 1'b0;
			cfg_q.enroll_frames <= scc_pkg::ENROLL_FRAMES_RST;
			cfg_q.missing_limit <= scc_pkg::MISSING_LIMIT_RST;
			cfg_q.stop_slot_a   <= '0;
			cfg_q.stop_slot_b   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				scc_pkg::CFG_BUS_RUNNING:   cfg_q.bus_running   <= cfg_wdata[0];
				scc_pkg::CFG_ENROLL_FRAMES: cfg_q.enroll_frames <= cfg_wdata;
				scc_pkg::CFG_MISSING_LIMIT: cfg_q.missing_limit <= cfg_wdata;
				scc_pkg::CFG_STOP_SLOT_A:   cfg_q.stop_slot_a   <=
					cfg_wdata[scc_pkg::SLOT_IDX_W-1:0];
				scc_pkg::CFG_STOP_SLOT_B:   cfg_q.stop_slot_b   <=
					cfg_wdata[scc_pkg::SLOT_IDX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv       = !out_v_q || res.ready;
	assign go        = req_v_s1 && adv;
	assign req.ready = !req_v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_v_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			req_v_s1 <= 1'b1;
		end else if (adv) begin
			req_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.op             <= req.op;
			req_s1.frame_mask     <= req.frame_mask;
			req_s1.photo_required <= req.photo_required;
		end
	end

	scc_core #(
		.SLOT_COUNT   (SLOT_COUNT),
		.HEADER_SLOTS (HEADER_SLOTS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.req    (req_s1),
		.cfg    (cfg_q),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (go) begin
			out_v_q <= 1'b1;
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_q <= core_res;
		end
	end

	assign res.valid          = out_v_q;
	assign res.motion_ok      = out_q.motion_ok;
	assign res.enrolled       = out_q.enrolled;
	assign res.roll_fault     = out_q.roll_fault;
	assign res.intruder_slots = out_q.intruder_slots;
	assign res.enrolled_slots = out_q.enrolled_slots;

endmodule

// ----- rtl/core/scc_checker.sv -----
module scc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic                       motion_ok,
	input logic                       enrolled,
	input logic                       roll_fault,
	input logic [scc_pkg::MASK_W-1:0] intruder_slots,
	input logic [scc_pkg::MASK_W-1:0] enrolled_slots
);

	// Consent is only ever given by a healthy, enrolled bus with no intruders.
	a_consent_safe: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && motion_ok |-> enrolled && !roll_fault && (intruder_slots == '0))
		else $error("consent given while enrolment, fault or intruder state forbids it");

	a_intruder_window: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((intruder_slots & ~scc_pkg::INTRUDER_WINDOW) == '0))
		else $error("intruder reported outside the intruder window");

	a_header_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !enrolled_slots[0])
		else $error("header slot reported as enrolled");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(motion_ok) && $stable(enrolled) &&
			$stable(roll_fault) && $stable(intruder_slots) && $stable(enrolled_slots))
		else $error("result item changed while stalled");

endmodule

bind slot_census_and_consent_unit scc_checker u_scc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.motion_ok      (res.motion_ok),
	.enrolled       (res.enrolled),
	.roll_fault     (res.roll_fault),
	.intruder_slots (res.intruder_slots),
	.enrolled_slots (res.enrolled_slots)
);

// ----- sim/slot_census_and_consent_unit_test.sv -----
`timescale 1ns / 1ps

module slot_census_and_consent_unit_test;
	import scc_pkg::*;

	localparam logic [1:0]        OP_UNUSED   = 2'd3;
	localparam logic [MASK_W-1:0] ALL_SLOTS   = {MASK_W{1'b1}};
	localparam logic [MASK_W-1:0] HEADER_MASK = (64'd1 << HEADER_SLOTS_DEF) - 64'd1;
	localparam logic [MASK_W-1:0] USABLE      =
		~HEADER_MASK & (ALL_SLOTS >> (MASK_W - SLOT_COUNT_DEF));
	localparam int                CYCLE_LIMIT = 200000;

	class census_tracker;
		cfg_t              cfg;
		logic [MASK_W-1:0] roster;
		logic [MASK_W-1:0] accum;
		logic [MASK_W-1:0] last_seen;
		logic [MASK_W-1:0] intruders;
		logic              roster_valid;
		logic              enrolling;
		logic              fault;
		logic [CNT_W-1:0]  frames_taken;
		logic [CNT_W-1:0]  absence [SLOT_COUNT_DEF];
		res_t              expected_answers [$];
		int                errors;

		function new();
			cfg.bus_running   = 1'b0;
			cfg.enroll_frames = ENROLL_FRAMES_RST;
			cfg.missing_limit = MISSING_LIMIT_RST;
			cfg.stop_slot_a   = '0;
			cfg.stop_slot_b   = '0;
			roster            = '0;
			accum             = '0;
			last_seen         = '0;
			intruders         = '0;
			roster_valid      = 1'b0;
			enrolling         = 1'b0;
			fault             = 1'b0;
			frames_taken      = '0;
			errors            = 0;
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_BUS_RUNNING:   cfg.bus_running   = val[0];
				CFG_ENROLL_FRAMES: cfg.enroll_frames = val;
				CFG_MISSING_LIMIT: cfg.missing_limit = val;
				CFG_STOP_SLOT_A:   cfg.stop_slot_a   = val[SLOT_IDX_W-1:0];
				CFG_STOP_SLOT_B:   cfg.stop_slot_b   = val[SLOT_IDX_W-1:0];
				default: ;
			endcase
		endfunction

		function void absorb_frame(logic [MASK_W-1:0] raw);
			logic [MASK_W-1:0] m;
			m = raw & USABLE;
			last_seen = m;
			if (enrolling) begin
				accum &= m;
				if (frames_taken != CNT_MAX)
					frames_taken++;
				if (frames_taken >= cfg.enroll_frames) begin
					roster = accum & USABLE;
					roster_valid = 1'b1;
					enrolling = 1'b0;
					foreach (absence[s])
						absence[s] = '0;
				end
				return;
			end
			if (!roster_valid)
				return;
			fault = 1'b0;
			for (int s = HEADER_SLOTS_DEF; s < SLOT_COUNT_DEF; s++) begin
				if (!roster[s])
					continue;
				if (s == cfg.stop_slot_a || s == cfg.stop_slot_b)
					continue;
				if (m[s])
					absence[s] = '0;
				else if (absence[s] != CNT_MAX)
					absence[s]++;
				if (absence[s] >= cfg.missing_limit)
					fault = 1'b1;
			end
			intruders = m & ~roster & INTRUDER_WINDOW;
		endfunction

		function logic stop_open(logic [SLOT_IDX_W-1:0] slot);
			return roster[slot] ? last_seen[slot] : 1'b1;
		endfunction

		function logic grant(logic [MASK_W-1:0] photo);
			if (!cfg.bus_running || !roster_valid || fault || intruders != '0)
				return 1'b0;
			if ((last_seen & photo) != photo)
				return 1'b0;
			if (!stop_open(cfg.stop_slot_a) || !stop_open(cfg.stop_slot_b))
				return 1'b0;
			return 1'b1;
		endfunction

		function void take_request(logic [1:0] op, logic [MASK_W-1:0] fm,
				logic [MASK_W-1:0] pr);
			res_t want;
			want.motion_ok = 1'b0;
			case (op)
				OP_ENROLL: begin
					accum = ALL_SLOTS;
					frames_taken = '0;
					enrolling = 1'b1;
					roster_valid = 1'b0;
				end
				OP_FRAME: absorb_frame(fm);
				OP_CONSENT: want.motion_ok = grant(pr);
				default: ;
			endcase
			want.enrolled = roster_valid;
			want.roll_fault = fault;
			want.intruder_slots = intruders;
			want.enrolled_slots = roster;
			expected_answers.push_back(want);
		endfunction

		function void compare(string field, logic [MASK_W-1:0] want, logic [MASK_W-1:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("%s mismatch: expected %h, got %h", field, want, got);
			end
		endfunction

		function void check_answer(res_t got);
			res_t want;
			if (expected_answers.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result %h arrived with no request outstanding", got);
				return;
			end
			want = expected_answers.pop_front();
			compare("motion_ok", MASK_W'(want.motion_ok), MASK_W'(got.motion_ok));
			compare("enrolled", MASK_W'(want.enrolled), MASK_W'(got.enrolled));
			compare("roll_fault", MASK_W'(want.roll_fault), MASK_W'(got.roll_fault));
			compare("intruder_slots", want.intruder_slots, got.intruder_slots);
			compare("enrolled_slots", want.enrolled_slots, got.enrolled_slots);
		endfunction

		function int pending();
			return expected_answers.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int                src_idle_pct    = 0;
	int                sink_stall_pct  = 0;
	int                hold_left       = 0;
	int                cycles          = 0;
	int                gap_slot        = HEADER_SLOTS_DEF;
	int                gap_run         = 0;
	logic [MASK_W-1:0] roll_mask       = '0;
	logic [MASK_W-1:0] last_frame_sent = '0;
	census_tracker     tracker         = new();

	scc_req_if request();
	scc_res_if answer();

	slot_census_and_consent_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (request),
		.res       (answer)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && request.valid && request.ready)
			tracker.take_request(request.op, request.frame_mask, request.photo_required);
		if (arst_n && answer.valid && answer.ready)
			tracker.check_answer({answer.motion_ok, answer.enrolled, answer.roll_fault,
				answer.intruder_slots, answer.enrolled_slots});
	end

	// The receiver honours a pending hold-off before any random stalling.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			answer.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			answer.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	function automatic logic [MASK_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [MASK_W-1:0] pick_roster();
		logic [MASK_W-1:0] r;
		r = rand64() & USABLE;
		if ($urandom_range(3) == 0)
			r &= INTRUDER_WINDOW;
		return r;
	endfunction

	// Frames mostly repeat the roster, with bursts of one absent slot and some noise.
	function automatic logic [MASK_W-1:0] frame_from_roll();
		logic [MASK_W-1:0] fm;
		int                v;
		fm = roll_mask;
		v = $urandom_range(99);
		if (gap_run == 0 && $urandom_range(14) == 0) begin
			gap_run = $urandom_range(10, 1);
			gap_slot = $urandom_range(SLOT_COUNT_DEF - 1, HEADER_SLOTS_DEF);
		end
		if (gap_run != 0) begin
			fm[gap_slot] = 1'b0;
			gap_run--;
		end
		if (v < 10)
			fm |= rand64() & HEADER_MASK;
		else if (v < 18)
			fm[$urandom_range(31, HEADER_SLOTS_DEF)] = 1'b1;
		else if (v < 24)
			fm |= rand64() & ~INTRUDER_WINDOW;
		else if (v < 32)
			fm = rand64();
		else if (v < 38) begin
			fm[tracker.cfg.stop_slot_a] = 1'b0;
			fm[tracker.cfg.stop_slot_b] = 1'b0;
		end
		return fm;
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [MASK_W-1:0] fm,
			input logic [MASK_W-1:0] pr);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			request.valid <= 1'b0;
			@(negedge clk);
		end
		request.valid <= 1'b1;
		request.op <= op;
		request.frame_mask <= fm;
		request.photo_required <= pr;
		if (op == OP_FRAME)
			last_frame_sent = fm;
		@(posedge clk);
		while (!request.ready)
			@(posedge clk);
	endtask

	task automatic quiesce();
		@(negedge clk);
		request.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic reconfigure(input logic bus, input logic [CFG_DATA_W-1:0] frames,
			input logic [CFG_DATA_W-1:0] limit, input logic [CFG_DATA_W-1:0] stop_a,
			input logic [CFG_DATA_W-1:0] stop_b);
		logic [CFG_IDX_W-1:0]  idx [5];
		logic [CFG_DATA_W-1:0] val [5];
		idx = '{CFG_BUS_RUNNING, CFG_ENROLL_FRAMES, CFG_MISSING_LIMIT,
			CFG_STOP_SLOT_A, CFG_STOP_SLOT_B};
		val = '{{7'd0, bus}, frames, limit, stop_a, stop_b};
		quiesce();
		for (int i = 0; i < 5; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_idx <= idx[i];
			cfg_wdata <= val[i];
			tracker.configure(idx[i], val[i]);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_items(input int count);
		int                pick;
		int                enroll_odds;
		int                v;
		logic [MASK_W-1:0] pr;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(999);
			enroll_odds = 1000 / (3 * int'(tracker.cfg.enroll_frames) + 25);
			if (pick < enroll_odds) begin
				roll_mask = pick_roster();
				send_item(OP_ENROLL, rand64(), rand64());
			end else if (pick < enroll_odds + 15) begin
				send_item(OP_UNUSED, rand64(), rand64());
			end else if (pick < enroll_odds + 575) begin
				send_item(OP_FRAME, frame_from_roll(), rand64());
			end else begin
				v = $urandom_range(99);
				if (v < 50)
					pr = last_frame_sent & USABLE & rand64();
				else if (v < 65)
					pr = '0;
				else if (v < 75)
					pr = (last_frame_sent & USABLE)
						| (64'd1 << $urandom_range(HEADER_SLOTS_DEF - 1, 0));
				else if (v < 85)
					pr = (last_frame_sent & USABLE)
						| (64'd1 << $urandom_range(SLOT_COUNT_DEF - 1, HEADER_SLOTS_DEF));
				else
					pr = rand64();
				send_item(OP_CONSENT, rand64(), pr);
			end
		end
	endtask

	initial begin
		logic [MASK_W-1:0] fm;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		request.valid = 1'b0;
		request.op = '0;
		request.frame_mask = '0;
		request.photo_required = '0;
		answer.ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		send_item(OP_CONSENT, '0, '0);
		send_item(OP_UNUSED, ALL_SLOTS, ALL_SLOTS);
		send_item(OP_FRAME, ALL_SLOTS, '0);
		send_item(OP_FRAME, '0, ALL_SLOTS);
		reconfigure(1'b1, 8'd1, 8'd1, 8'd9, 8'd0);
		send_item(OP_ENROLL, '0, '0);
		send_item(OP_FRAME, ALL_SLOTS, '0);
		send_item(OP_CONSENT, '0, '0);
		send_item(OP_CONSENT, '0, ALL_SLOTS);
		send_item(OP_CONSENT, '0, USABLE);
		send_item(OP_FRAME, ~(64'd1 << 20), '0);
		send_item(OP_CONSENT, '0, '0);
		send_item(OP_FRAME, ~(64'd1 << 9), '0);
		send_item(OP_CONSENT, '0, '0);
		send_item(OP_FRAME, ALL_SLOTS, '0);
		send_item(OP_ENROLL, '0, '0);
		send_item(OP_FRAME, 64'h0000_0000_0000_FFFF, '0);
		send_item(OP_FRAME, 64'h0000_0100_0010_FF00, '0);
		send_item(OP_CONSENT, '0, '0);
		send_item(OP_FRAME, '0, '0);
		send_item(OP_FRAME, 64'h0000_0000_0000_FF00, '0);
		send_item(OP_CONSENT, '0, 64'h8000_0000_0000_0000);
		send_item(OP_CONSENT, '0, 64'h0000_0000_0000_FF00);
		send_item(OP_ENROLL, '0, '0);
		send_item(OP_CONSENT, '0, '0);
		send_item(OP_FRAME, 64'h0000_0000_0000_FF00, '0);
		roll_mask = 64'h0000_0000_0000_FF00;

		reconfigure(1'b1, 8'd3, 8'd3, 8'd12, 8'd30);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		random_items(160);

		reconfigure(1'b1, 8'd1, 8'd1, 8'd0, 8'd63);
		src_idle_pct = 45;
		sink_stall_pct = 0;
		random_items(160);

		reconfigure(1'b0, 8'd5, 8'd255, 8'd63, 8'd8);
		src_idle_pct = 0;
		sink_stall_pct = 45;
		random_items(150);

		reconfigure(1'b1, 8'd2, 8'd2, 8'd15, 8'd15);
		src_idle_pct = 17;
		sink_stall_pct = 17;
		@(posedge clk);
		hold_left = 300;
		random_items(180);

		reconfigure(1'b1, 8'd0, 8'd0, 8'd31, 8'd32);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		random_items(150);

		// The longest enrollment, fed with roster frames that only rarely lose a slot.
		reconfigure(1'b1, 8'd255, 8'd4, 8'd40, 8'd0);
		src_idle_pct = 45;
		sink_stall_pct = 0;
		roll_mask = pick_roster();
		send_item(OP_ENROLL, rand64(), rand64());
		for (int n = 0; n < 258; n++) begin
			fm = roll_mask | (rand64() & HEADER_MASK);
			if ($urandom_range(39) == 0)
				fm[$urandom_range(SLOT_COUNT_DEF - 1, HEADER_SLOTS_DEF)] = 1'b0;
			send_item(OP_FRAME, fm, rand64());
		end
		random_items(100);

		reconfigure(1'b1, 8'd50, 8'd5, 8'd0, 8'd0);
		src_idle_pct = 0;
		sink_stall_pct = 45;
		random_items(180);

		// Only the low six bits of the stop slot data reach the register.
		reconfigure(1'b1, 8'd4, 8'd6, 8'hD4, 8'd50);
		src_idle_pct = 17;
		sink_stall_pct = 17;
		random_items(150);

		quiesce();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
